>>> rtl/fqd_pkg.sv
// fqd_pkg: shared constants, request codes and cell control type for the
// queue with delete-by-value; no dependencies
package fqd_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);

    // stream widths and field positions
    localparam int S_TDATA_W     = 32;
    localparam int S_TUSER_W     = 2;
    localparam int IN_VALUE_W    = 32;
    localparam int OUT_VALUE_W   = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int M_VALID_BIT   = OUT_VALUE_W;
    localparam int M_FOUND_BIT   = OUT_VALUE_W + 1;
    localparam int M_DROPPED_BIT = OUT_VALUE_W + 2;
    localparam int M_EMPTY_BIT   = OUT_VALUE_W + 3;
    localparam int M_COUNT_LSB   = OUT_VALUE_W + 4;
    localparam int M_USED_W      = M_COUNT_LSB + ENTRY_COUNT_W;
    localparam int M_TDATA_W     = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W       = M_TDATA_W - M_USED_W;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef logic [VALUE_BITS-1:0] value_t;

    // request broadcast to every cell of the chain
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   del;
        value_t key;
    } cell_ctrl_t;

endpackage

>>> rtl/fqd_cell.sv
// fqd_cell: one queue slot; loads at the tail, shifts from its neighbor on
// pop or on a delete at or ahead of it; depends on fqd_pkg
module fqd_cell
    import fqd_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       live,        // slot holds an entry
    input  logic       tail,        // slot is the first free one
    input  value_t     next_value,  // neighbor toward the back
    input  logic       hit_in,      // a match was found closer to the front
    output logic       hit_out,
    output value_t     value
);

    value_t value_reg;
    value_t value_next;
    logic   match;
    logic   shift;

    assign match   = ctrl.del && live && (value_reg == ctrl.key);
    assign hit_out = hit_in || match;
    assign shift   = ctrl.pop || (ctrl.del && hit_out);

    always_comb begin
        value_next = value_reg;
        if (shift) begin
            value_next = next_value;
        end else if (ctrl.push && tail) begin
            value_next = ctrl.key;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/fifo_queue_with_delete_top.sv
// fifo_queue_with_delete_top: ordered queue with push, pop and delete-by-value
// built as a chain of fqd_cell slots; depends on fqd_pkg and fqd_cell
// result: registered, and on m_tdata in the cycle after the request transfer
// throughput: one request per cycle while the result side keeps taking transfers;
//   the delete search ripples a match flag through all DEPTH cells in that cycle
// reset: occupancy and the result valid clear; slot contents are not cleared
module fifo_queue_with_delete_top
    import fqd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] func
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] out_value, [32] out_valid,
                                            // [33] found, [34] dropped,
                                            // [35] is_empty, [40:36] entry_count,
                                            // [47:41] zero
);

    logic [COUNT_W-1:0]   occ_reg;
    logic [COUNT_W-1:0]   occ_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic       in_fire;
    func_t      func;
    cell_ctrl_t ctrl;
    logic       full;
    logic       empty;
    logic       found;

    value_t     cell_value [DEPTH];
    logic       hit_chain  [DEPTH+1];

    // result register frees as soon as the consumer takes it
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);

    assign full  = (occ_reg == COUNT_W'(DEPTH));
    assign empty = (occ_reg == '0);

    // request broadcast, gated by the transfer
    always_comb begin
        ctrl.push = in_fire && (func == FUNC_PUSH);
        ctrl.pop  = in_fire && (func == FUNC_POP);
        ctrl.del  = in_fire && (func == FUNC_DELETE);
        ctrl.key  = VALUE_BITS'(s_tdata[IN_VALUE_W-1:0]);
    end

    // slot chain, front at cell 0
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        value_t next_value;
        if (i == DEPTH - 1) begin : g_last
            assign next_value = cell_value[i];
        end else begin : g_mid
            assign next_value = cell_value[i+1];
        end

        fqd_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .live       (COUNT_W'(i) < occ_reg),
            .tail       (COUNT_W'(i) == occ_reg),
            .next_value (next_value),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .value      (cell_value[i])
        );
    end

    assign found = hit_chain[DEPTH];

    // occupancy update and result word
    always_comb begin
        logic                   r_valid;
        logic                   r_found;
        logic                   r_dropped;
        logic [OUT_VALUE_W-1:0] r_value;

        occ_next  = occ_reg;
        r_valid   = 1'b0;
        r_found   = 1'b0;
        r_dropped = 1'b0;
        r_value   = '0;

        case (func)
            FUNC_PUSH: begin
                if (full) begin
                    r_dropped = 1'b1;
                end else begin
                    occ_next = occ_reg + COUNT_W'(1);
                end
            end
            FUNC_POP: begin
                if (!empty) begin
                    r_valid  = 1'b1;
                    r_value  = OUT_VALUE_W'(cell_value[0]);
                    occ_next = occ_reg - COUNT_W'(1);
                end
            end
            FUNC_DELETE: begin
                if (found) begin
                    r_found  = 1'b1;
                    occ_next = occ_reg - COUNT_W'(1);
                end
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase

        m_tdata_next = {{M_PAD_W{1'b0}},
                        ENTRY_COUNT_W'(occ_next),
                        (occ_next == '0),
                        r_dropped,
                        r_found,
                        r_valid,
                        r_value};

        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (in_fire) begin
            m_tvalid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (in_fire) begin
                occ_reg <= occ_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/fqd_checker.sv
// fqd_checker: port-level checks on the queue results, bound to the top level;
// depends on fqd_pkg
module fqd_checker
    import fqd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // empty flag agrees with the count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_EMPTY_BIT] ==
                      (m_tdata[M_COUNT_LSB +: ENTRY_COUNT_W] == '0)))
        else $error("empty flag does not match entry count");

    // count never exceeds the depth
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_COUNT_LSB +: ENTRY_COUNT_W] <= ENTRY_COUNT_W'(DEPTH)))
        else $error("entry count above depth");

    // a result carries at most one of the per-kind flags
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({m_tdata[M_VALID_BIT], m_tdata[M_FOUND_BIT],
                               m_tdata[M_DROPPED_BIT]}))
        else $error("more than one result flag set");

    // value is zero unless a pop returned an entry
    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_VALID_BIT] |-> (m_tdata[OUT_VALUE_W-1:0] == '0))
        else $error("nonzero value without a popped entry");

endmodule

bind fifo_queue_with_delete_top fqd_checker u_fqd_checker (.*);
